>>> hw/rtl/qpt_pkg.sv
`timescale 1ns / 1ps

package qpt_pkg;

    // Field widths of the streams and the configuration port.
    localparam int POS_W      = 32;
    localparam int Q_W        = 20;
    localparam int T_W        = 24;
    localparam int ANG_W      = 20;
    localparam int TDATA_W    = 3 * POS_W + 4 * Q_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_SPACE = 3'd6;

    // Point-space rotation matrix and its divider.
    localparam int SQ_W      = 2 * Q_W;       // one product of two quaternion parts
    localparam int M_W       = SQ_W + 2;      // matrix entry before the divide
    localparam int N2_W      = SQ_W + 1;      // squared norm, unsigned
    localparam int DIV_STEPS = 30;            // fraction bits of the Q30 quotient
    localparam int TQ_W      = DIV_STEPS + 2; // signed Q30 matrix entry
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // CORDIC constants in Q30.
    localparam int  CW           = 34;
    localparam longint GAIN_Q30    = 64'sh26DD3B6A;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [Q_W-1:0]   q_x;
        logic signed [Q_W-1:0]   q_y;
        logic signed [Q_W-1:0]   q_z;
        logic signed [Q_W-1:0]   q_w;
    } item_t;

    // Number of conditional subtract stages that bring the scaled half angle
    // below two pi.
    function automatic int cordic_red_steps(input int frac_bits);
        int zw;
        zw = ANG_W + 29 - frac_bits;
        return (zw > 32) ? zw - 32 : 1;
    endfunction

    // Truncated arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/qpt_frac_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: round(num * 2^30 / den) for |num| <= den,
// one quotient bit per stage.
module qpt_frac_div import qpt_pkg::*; (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [M_W-1:0]  num,
    input  logic [N2_W-1:0]        den,
    output logic signed [TQ_W-1:0] quot
);

    logic [N2_W-1:0]      rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS:0]   quo_reg [0:DIV_STEPS];
    logic [N2_W-1:0]      den_reg [0:DIV_STEPS];
    logic                 neg_reg [0:DIV_STEPS];
    logic signed [TQ_W-1:0] quot_reg;

    logic signed [M_W-1:0] abs_num;
    logic [N2_W-1:0]       mag;
    logic                  first_bit;
    logic [TQ_W-1:0]       q_round;
    logic                  rnd_up;

    assign abs_num   = num[M_W-1] ? -num : num;
    assign mag       = abs_num[N2_W-1:0];
    assign first_bit = (mag >= den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= first_bit ? mag - den : mag;
            quo_reg[0] <= {{DIV_STEPS{1'b0}}, first_bit};
            den_reg[0] <= den;
            neg_reg[0] <= num[M_W-1];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [N2_W:0] r2;
        logic [N2_W:0] rsub;
        logic          ge;
        assign r2   = {rem_reg[j], 1'b0};
        assign ge   = (r2 >= {1'b0, den_reg[j]});
        assign rsub = r2 - {1'b0, den_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? rsub[N2_W-1:0] : r2[N2_W-1:0];
                quo_reg[j+1] <= {quo_reg[j][DIV_STEPS-1:0], ge};
                den_reg[j+1] <= den_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    // Round half up on the remainder, then restore the sign.
    assign rnd_up  = ({rem_reg[DIV_STEPS], 1'b0} >= {1'b0, den_reg[DIV_STEPS]});
    assign q_round = {1'b0, quo_reg[DIV_STEPS]} + {{(TQ_W-1){1'b0}}, rnd_up};

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= neg_reg[DIV_STEPS] ? -$signed(q_round) : $signed(q_round);
        end
    end

    assign quot = quot_reg;

endmodule

>>> hw/rtl/qpt_cordic.sv
`timescale 1ns / 1ps

// Free-running pipelined sine and cosine of half an angle.
module qpt_cordic import qpt_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        aclk,
    input  logic signed [ANG_W-1:0]     angle,
    output logic signed [FRAC_BITS+1:0] sin_o,
    output logic signed [FRAC_BITS+1:0] cos_o
);

    localparam int SH        = 29 - FRAC_BITS;
    localparam int ZW        = ANG_W + SH;
    localparam int RED_STEPS = cordic_red_steps(FRAC_BITS);
    localparam int RW        = 33 + RED_STEPS;
    localparam int SCW       = FRAC_BITS + 2;

    localparam logic [RW-1:0]        TWO_PI_R = RW'(TWO_PI_Q30);
    localparam logic signed [CW-1:0] PI_C     = CW'(PI_Q30);
    localparam logic signed [CW-1:0] HALF_C   = CW'(HALF_PI_Q30);
    localparam logic signed [CW-1:0] TWO_PI_C = CW'(TWO_PI_Q30);
    localparam logic signed [CW-1:0] GAIN_C   = CW'(GAIN_Q30);
    localparam logic signed [CW-1:0] RND_C    = CW'(1) <<< (29 - FRAC_BITS);

    logic [RW-1:0]        mag_reg [0:RED_STEPS];
    logic                 neg_reg [0:RED_STEPS];
    logic signed [CW-1:0] wrap_reg;
    logic signed [CW-1:0] cx_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0] cz_reg  [0:CORDIC_STEPS];
    logic                 flip_reg [0:CORDIC_STEPS];
    logic signed [SCW-1:0] sin_reg;
    logic signed [SCW-1:0] cos_reg;

    logic signed [ZW:0]   z_ext;
    logic signed [ZW:0]   z_abs;
    logic signed [CW-1:0] v_signed;
    logic signed [CW-1:0] wrap_next;
    logic signed [CW-1:0] fold_next;
    logic                 flip_next;
    logic signed [CW-1:0] x_rnd;
    logic signed [CW-1:0] y_rnd;

    // The half angle in Q30 is the angle shifted up by 29 - FRAC_BITS.
    assign z_ext = {angle[ANG_W-1], angle, {SH{1'b0}}};
    assign z_abs = angle[ANG_W-1] ? -z_ext : z_ext;

    always_ff @(posedge aclk) begin
        mag_reg[0] <= RW'($unsigned(z_abs));
        neg_reg[0] <= angle[ANG_W-1];
    end

    // Remainder by two pi on the magnitude, largest multiple first.
    for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
        localparam logic [RW-1:0] SUB = TWO_PI_R << (RED_STEPS - 1 - k);
        always_ff @(posedge aclk) begin
            mag_reg[k+1] <= (mag_reg[k] >= SUB) ? mag_reg[k] - SUB : mag_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_comb begin
        v_signed = $signed({1'b0, mag_reg[RED_STEPS][32:0]});
        if (neg_reg[RED_STEPS]) begin
            v_signed = -v_signed;
        end
        if (v_signed > PI_C) begin
            wrap_next = v_signed - TWO_PI_C;
        end else if (v_signed < -PI_C) begin
            wrap_next = v_signed + TWO_PI_C;
        end else begin
            wrap_next = v_signed;
        end
    end

    // Beyond a quarter turn the angle moves by pi and both outputs change sign.
    always_comb begin
        flip_next = 1'b1;
        if (wrap_reg > HALF_C) begin
            fold_next = wrap_reg - PI_C;
        end else if (wrap_reg < -HALF_C) begin
            fold_next = wrap_reg + PI_C;
        end else begin
            fold_next = wrap_reg;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        wrap_reg    <= wrap_next;
        cx_reg[0]   <= GAIN_C;
        cy_reg[0]   <= '0;
        cz_reg[0]   <= fold_next;
        flip_reg[0] <= flip_next;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [CW-1:0] ATAN_C = $signed({2'b00, atan_q30(i)});
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (cz_reg[i] >= 0) begin
                cx_reg[i+1] <= cx_reg[i] - dx;
                cy_reg[i+1] <= cy_reg[i] + dy;
                cz_reg[i+1] <= cz_reg[i] - ATAN_C;
            end else begin
                cx_reg[i+1] <= cx_reg[i] + dx;
                cy_reg[i+1] <= cy_reg[i] - dy;
                cz_reg[i+1] <= cz_reg[i] + ATAN_C;
            end
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    assign x_rnd = (cx_reg[CORDIC_STEPS] + RND_C) >>> (30 - FRAC_BITS);
    assign y_rnd = (cy_reg[CORDIC_STEPS] + RND_C) >>> (30 - FRAC_BITS);

    always_ff @(posedge aclk) begin
        sin_reg <= flip_reg[CORDIC_STEPS] ? -y_rnd[SCW-1:0] : y_rnd[SCW-1:0];
        cos_reg <= flip_reg[CORDIC_STEPS] ? -x_rnd[SCW-1:0] : x_rnd[SCW-1:0];
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

>>> hw/rtl/qpt_ypr_quat.sv
`timescale 1ns / 1ps

// Builds the yaw-pitch-roll quaternion from the half-angle sines and cosines.
// Two free-running stages; every pairwise product is rounded half up.
module qpt_ypr_quat import qpt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic signed [FRAC_BITS+1:0] sy,
    input  logic signed [FRAC_BITS+1:0] cy,
    input  logic signed [FRAC_BITS+1:0] sp,
    input  logic signed [FRAC_BITS+1:0] cp,
    input  logic signed [FRAC_BITS+1:0] sr,
    input  logic signed [FRAC_BITS+1:0] cr,
    output logic signed [FRAC_BITS+2:0] b_x,
    output logic signed [FRAC_BITS+2:0] b_y,
    output logic signed [FRAC_BITS+2:0] b_z,
    output logic signed [FRAC_BITS+2:0] b_w
);

    localparam int SCW = FRAC_BITS + 2;
    localparam int BW  = FRAC_BITS + 3;
    localparam int PW  = 2 * SCW;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [SCW-1:0] cc_reg, ss_reg, sc_reg, cs_reg, sr_reg, cr_reg;
    logic signed [BW-1:0]  bx_reg, by_reg, bz_reg, bw_reg;

    function automatic logic signed [SCW-1:0] mulq(
        input logic signed [SCW-1:0] a,
        input logic signed [SCW-1:0] b
    );
        logic signed [PW-1:0] p;
        p = ((a * b) + HALF_P) >>> FRAC_BITS;
        return p[SCW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        cc_reg <= mulq(cy, cp);
        ss_reg <= mulq(sy, sp);
        sc_reg <= mulq(sy, cp);
        cs_reg <= mulq(cy, sp);
        sr_reg <= sr;
        cr_reg <= cr;
    end

    always_ff @(posedge aclk) begin
        bx_reg <= BW'(mulq(cs_reg, cr_reg)) + BW'(mulq(sc_reg, sr_reg));
        by_reg <= BW'(mulq(sc_reg, cr_reg)) - BW'(mulq(cs_reg, sr_reg));
        bz_reg <= BW'(mulq(cc_reg, sr_reg)) - BW'(mulq(ss_reg, cr_reg));
        bw_reg <= BW'(mulq(cc_reg, cr_reg)) + BW'(mulq(ss_reg, sr_reg));
    end

    assign b_x = bx_reg;
    assign b_y = by_reg;
    assign b_z = bz_reg;
    assign b_w = bw_reg;

endmodule

>>> hw/rtl/quaternion_point_transform_unit.sv
`timescale 1ns / 1ps

// Quaternion point transform.
// One point (position x/y/z in Q16.16, orientation quaternion x/y/z/w) enters
// on the s_ stream and the transformed point leaves on the m_ stream, both
// packed into tdata with pos_x in the lowest bits. The orientation is
// post-multiplied by a quaternion made from the yaw, pitch and roll registers;
// the position is offset by the translation registers, which in point-space
// mode are first rotated by the point's own orientation.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata. The user
// must write them only while no transaction is in flight; the block does not
// enforce this. The path from an accepted input transaction to its output
// runs through the matrix stages, the 32-stage divider that normalizes the
// point-space rotation matrix, and stages A, B and C. Throughput is one
// transaction per cycle while the receiver keeps up and no write is settling.
// The yaw-pitch-roll quaternion comes from a free-running CORDIC pipeline fed
// by the angle registers. After reset and after every register write s_tready
// stays low until that pipeline holds the new value.
// When m_tvalid is high and the receiver holds m_tready low, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated. Reset
// clears all valid bits and the registers.
module quaternion_point_transform_unit import qpt_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: pos_x, pos_y, pos_z, orient_x, orient_y, orient_z,
    // orient_w.
    input  logic [TDATA_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: out_pos_x, out_pos_y, out_pos_z, out_orient_x,
    // out_orient_y, out_orient_z, out_orient_w.
    output logic [TDATA_W-1:0]    m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SCW       = FRAC_BITS + 2;
    localparam int BW        = FRAC_BITS + 3;
    localparam int RED_STEPS = cordic_red_steps(FRAC_BITS);
    localparam int SETTLE    = RED_STEPS + CORDIC_STEPS + 7;
    localparam int SETTLE_W  = $clog2(SETTLE + 1);

    // Pipeline stages: two for the matrix, the divider, then A, B and C.
    localparam int ITEM_LAT = 2 + DIV_LAT;
    localparam int PIPE_LAT = ITEM_LAT + 3;

    localparam int TP_W = TQ_W + T_W;        // matrix entry times translation
    localparam int TS_W = TP_W + 2;
    localparam int TR_W = T_W + 3;           // rotated translation
    localparam int OP_W = Q_W + BW;          // quaternion product term
    localparam int OS_W = OP_W + 2;

    localparam logic signed [TS_W-1:0] T_HALF = TS_W'(1) <<< 29;
    localparam logic signed [OS_W-1:0] O_HALF = OS_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [OS_W-1:0] O_MAX  = OS_W'((2 ** (Q_W - 1)) - 1);
    localparam logic signed [OS_W-1:0] O_MIN  = -OS_W'(2 ** (Q_W - 1));
    localparam logic signed [POS_W:0]  P_MAX  = {2'b00, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W:0]  P_MIN  = {2'b11, {(POS_W-1){1'b0}}};

    // Configuration registers.
    logic signed [T_W-1:0]   trans_reg [0:2];
    logic signed [ANG_W-1:0] yaw_reg, pitch_reg, roll_reg;
    logic                    point_space_reg;
    logic [SETTLE_W-1:0]     settle_reg;

    // Handshake and valid bits.
    logic adv;
    logic in_fire;
    logic vld_reg [0:PIPE_LAT-1];

    // Yaw-pitch-roll quaternion, ready while settle_reg is zero.
    logic signed [SCW-1:0] sy, cy, sp, cp, sr, cr;
    logic signed [BW-1:0]  b_q [0:3];

    // Item path.
    item_t                  in_item;
    item_t                  item_reg [0:ITEM_LAT-1];
    logic signed [SQ_W-1:0] prod_next [0:9];
    logic signed [SQ_W-1:0] prod_reg  [0:9];
    logic signed [M_W-1:0]  m_next    [0:8];
    logic signed [M_W-1:0]  m_reg     [0:8];
    logic [N2_W-1:0]        n2_reg;
    logic                   zero_reg  [0:DIV_LAT-1];
    logic signed [TQ_W-1:0] quot      [0:8];

    logic signed [TP_W-1:0] tp_reg [0:8];
    item_t                  item_a_reg;
    logic                   zero_a_reg;

    logic signed [TR_W-1:0] tr_b_reg [0:2];
    logic signed [POS_W-1:0] pos_b_reg [0:2];
    logic signed [OP_W-1:0] op_reg [0:3][0:3];

    logic signed [POS_W-1:0] out_pos_reg [0:2];
    logic signed [Q_W-1:0]   out_q_reg   [0:3];

    logic signed [Q_W-1:0]   q_a [0:3];
    logic signed [POS_W-1:0] pos_a [0:2];
    logic signed [TR_W-1:0]  tr_next [0:2];
    logic signed [OS_W-1:0]  o_sum [0:3];

    // ------------------------------------------------------------------
    // Configuration and settle counter.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                trans_reg[i] <= '0;
            end
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            roll_reg        <= '0;
            point_space_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRANS_X:     trans_reg[0]    <= cfg_wdata[T_W-1:0];
                REG_TRANS_Y:     trans_reg[1]    <= cfg_wdata[T_W-1:0];
                REG_TRANS_Z:     trans_reg[2]    <= cfg_wdata[T_W-1:0];
                REG_YAW:         yaw_reg         <= cfg_wdata[ANG_W-1:0];
                REG_PITCH:       pitch_reg       <= cfg_wdata[ANG_W-1:0];
                REG_ROLL:        roll_reg        <= cfg_wdata[ANG_W-1:0];
                REG_POINT_SPACE: point_space_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Holds the input off until the angle pipeline reflects the registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            settle_reg <= SETTLE_W'(SETTLE);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    qpt_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .aclk(aclk), .angle(yaw_reg), .sin_o(sy), .cos_o(cy)
    );
    qpt_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .aclk(aclk), .angle(pitch_reg), .sin_o(sp), .cos_o(cp)
    );
    qpt_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll (
        .aclk(aclk), .angle(roll_reg), .sin_o(sr), .cos_o(cr)
    );

    qpt_ypr_quat #(.FRAC_BITS(FRAC_BITS)) u_ypr (
        .aclk(aclk),
        .sy(sy), .cy(cy), .sp(sp), .cp(cp), .sr(sr), .cr(cr),
        .b_x(b_q[0]), .b_y(b_q[1]), .b_z(b_q[2]), .b_w(b_q[3])
    );

    // ------------------------------------------------------------------
    // Handshake: every stage advances together unless the output waits.
    // ------------------------------------------------------------------
    assign adv      = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = adv && (settle_reg == '0);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_fire;
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Matrix stages: component products, then entries and squared norm.
    // ------------------------------------------------------------------
    assign in_item.pos_x = s_tdata[31:0];
    assign in_item.pos_y = s_tdata[63:32];
    assign in_item.pos_z = s_tdata[95:64];
    assign in_item.q_x   = s_tdata[115:96];
    assign in_item.q_y   = s_tdata[135:116];
    assign in_item.q_z   = s_tdata[155:136];
    assign in_item.q_w   = s_tdata[175:156];

    // Order: xx, yy, zz, ww, xy, wz, xz, wy, yz, wx.
    assign prod_next[0] = in_item.q_x * in_item.q_x;
    assign prod_next[1] = in_item.q_y * in_item.q_y;
    assign prod_next[2] = in_item.q_z * in_item.q_z;
    assign prod_next[3] = in_item.q_w * in_item.q_w;
    assign prod_next[4] = in_item.q_x * in_item.q_y;
    assign prod_next[5] = in_item.q_w * in_item.q_z;
    assign prod_next[6] = in_item.q_x * in_item.q_z;
    assign prod_next[7] = in_item.q_w * in_item.q_y;
    assign prod_next[8] = in_item.q_y * in_item.q_z;
    assign prod_next[9] = in_item.q_w * in_item.q_x;

    always_comb begin
        m_next[0] = M_W'(prod_reg[3]) + M_W'(prod_reg[0]) - M_W'(prod_reg[1])
                    - M_W'(prod_reg[2]);
        m_next[1] = (M_W'(prod_reg[4]) - M_W'(prod_reg[5])) <<< 1;
        m_next[2] = (M_W'(prod_reg[6]) + M_W'(prod_reg[7])) <<< 1;
        m_next[3] = (M_W'(prod_reg[4]) + M_W'(prod_reg[5])) <<< 1;
        m_next[4] = M_W'(prod_reg[3]) - M_W'(prod_reg[0]) + M_W'(prod_reg[1])
                    - M_W'(prod_reg[2]);
        m_next[5] = (M_W'(prod_reg[8]) - M_W'(prod_reg[9])) <<< 1;
        m_next[6] = (M_W'(prod_reg[6]) - M_W'(prod_reg[7])) <<< 1;
        m_next[7] = (M_W'(prod_reg[8]) + M_W'(prod_reg[9])) <<< 1;
        m_next[8] = M_W'(prod_reg[3]) - M_W'(prod_reg[0]) - M_W'(prod_reg[1])
                    + M_W'(prod_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 10; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            for (int i = 0; i < 9; i++) begin
                m_reg[i] <= m_next[i];
            end
            n2_reg <= N2_W'($unsigned(prod_reg[0])) + N2_W'($unsigned(prod_reg[1]))
                    + N2_W'($unsigned(prod_reg[2])) + N2_W'($unsigned(prod_reg[3]));
            item_reg[0] <= in_item;
            for (int k = 1; k < ITEM_LAT; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
            // A zero quaternion gets a zero inverse; its divider results are
            // discarded further down.
            zero_reg[0] <= (n2_reg == '0);
            for (int k = 1; k < DIV_LAT; k++) begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_div
        qpt_frac_div u_div (
            .aclk(aclk), .en(adv), .num(m_reg[i]), .den(n2_reg), .quot(quot[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage A: matrix times translation.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    tp_reg[3*r+c] <= quot[3*r+c] * trans_reg[c];
                end
            end
            item_a_reg <= item_reg[ITEM_LAT-1];
            zero_a_reg <= zero_reg[DIV_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: rounded rotated translation; quaternion product terms.
    // ------------------------------------------------------------------
    assign q_a[0]   = item_a_reg.q_x;
    assign q_a[1]   = item_a_reg.q_y;
    assign q_a[2]   = item_a_reg.q_z;
    assign q_a[3]   = item_a_reg.q_w;
    assign pos_a[0] = item_a_reg.pos_x;
    assign pos_a[1] = item_a_reg.pos_y;
    assign pos_a[2] = item_a_reg.pos_z;

    always_comb begin
        logic signed [TS_W-1:0] s;
        for (int r = 0; r < 3; r++) begin
            s = TS_W'(tp_reg[3*r]) + TS_W'(tp_reg[3*r+1]) + TS_W'(tp_reg[3*r+2]) + T_HALF;
            s = s >>> 30;
            if (!point_space_reg) begin
                tr_next[r] = TR_W'(trans_reg[r]);
            end else if (zero_a_reg) begin
                tr_next[r] = '0;
            end else begin
                tr_next[r] = s[TR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                tr_b_reg[r]  <= tr_next[r];
                pos_b_reg[r] <= pos_a[r];
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    op_reg[i][j] <= q_a[i] * b_q[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: saturated sums into the output register.
    // ------------------------------------------------------------------
    assign o_sum[0] = OS_W'(op_reg[0][3]) + OS_W'(op_reg[3][0]) + OS_W'(op_reg[1][2])
                    - OS_W'(op_reg[2][1]);
    assign o_sum[1] = OS_W'(op_reg[1][3]) + OS_W'(op_reg[3][1]) + OS_W'(op_reg[2][0])
                    - OS_W'(op_reg[0][2]);
    assign o_sum[2] = OS_W'(op_reg[2][3]) + OS_W'(op_reg[3][2]) + OS_W'(op_reg[0][1])
                    - OS_W'(op_reg[1][0]);
    assign o_sum[3] = OS_W'(op_reg[3][3]) - (OS_W'(op_reg[0][0]) + OS_W'(op_reg[1][1])
                    + OS_W'(op_reg[2][2]));

    always_ff @(posedge aclk) begin
        logic signed [POS_W:0]  ps;
        logic signed [OS_W-1:0] os;
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                ps = (POS_W+1)'(pos_b_reg[r]) + (POS_W+1)'(tr_b_reg[r]);
                if (ps > P_MAX) begin
                    out_pos_reg[r] <= P_MAX[POS_W-1:0];
                end else if (ps < P_MIN) begin
                    out_pos_reg[r] <= P_MIN[POS_W-1:0];
                end else begin
                    out_pos_reg[r] <= ps[POS_W-1:0];
                end
            end
            for (int i = 0; i < 4; i++) begin
                os = (o_sum[i] + O_HALF) >>> FRAC_BITS;
                if (os > O_MAX) begin
                    out_q_reg[i] <= O_MAX[Q_W-1:0];
                end else if (os < O_MIN) begin
                    out_q_reg[i] <= O_MIN[Q_W-1:0];
                end else begin
                    out_q_reg[i] <= os[Q_W-1:0];
                end
            end
        end
    end

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = {out_q_reg[3], out_q_reg[2], out_q_reg[1], out_q_reg[0],
                       out_pos_reg[2], out_pos_reg[1], out_pos_reg[0]};

endmodule

>>> dv/tb_quaternion_point_transform_unit.sv
`timescale 1ns / 1ps

module tb_quaternion_point_transform_unit;
    import qpt_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0: pos_x, pos_y, pos_z, orient_x, orient_y, orient_z, orient_w.
    logic [TDATA_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0: out_pos_x, out_pos_y, out_pos_z, out_orient_x,
    // out_orient_y, out_orient_z, out_orient_w.
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    quaternion_point_transform_unit dut (.*);

    // Points waiting to be driven, and transformed points still to come back.
    logic [TDATA_W-1:0] pending_points[$];
    logic [TDATA_W-1:0] expected_points[$];

    // Appends one point to the queue that feeds the driver.
    task automatic enqueue_point(input logic [TDATA_W-1:0] pt);
        pending_points = {pending_points, pt};
    endtask

    // Shadow copy of the registers and the yaw-pitch-roll quaternion built from them.
    longint trans[3];
    longint ypr_x, ypr_y, ypr_z, ypr_w;
    bit     point_space;

    int  idle_pct;
    int  stall_pct;
    bit  in_fire;
    int  errors;
    int  points_checked;
    int  zero_quat_points;

    // Truncated arctangents of 2^-i in Q30, one per CORDIC rotation.
    longint atan_lut[16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q16(input longint a, input longint b);
        return round_shift(a * b, 16);
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // round(num * 2^30 / den) with rounding half away from zero.
    function automatic longint div_q30(input longint num, input longint den);
        longint unsigned a;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        a = (num < 0) ? -num : num;
        d = den;
        q = a / d;
        r = a % d;
        for (int i = 0; i < 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        if (2 * r >= d) q = q + 1;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Sine and cosine of half a Q16.16 angle, by CORDIC in Q30.
    task automatic half_angle_trig(input longint ang, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = ang * (longint'(1) <<< 13);
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        z = z % TWO_PI_Q30;
        if (z > PI_Q30) z -= TWO_PI_Q30;
        if (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_lut[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_lut[i];
            end
        end
        x = round_shift(x, 14);
        y = round_shift(y, 14);
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    // Drives one register and mirrors it, rebuilding the yaw-pitch-roll quaternion.
    longint ang_reg[3];
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        longint sy, cy, sp, cp, sr, cr, cc, ss, sc, cs;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TRANS_X, REG_TRANS_Y, REG_TRANS_Z:
                trans[idx] = longint'($signed(value[T_W-1:0]));
            REG_YAW, REG_PITCH, REG_ROLL:
                ang_reg[idx - REG_YAW] = longint'($signed(value[ANG_W-1:0]));
            REG_POINT_SPACE: point_space = value[0];
            default: ;
        endcase
        half_angle_trig(ang_reg[0], sy, cy);
        half_angle_trig(ang_reg[1], sp, cp);
        half_angle_trig(ang_reg[2], sr, cr);
        cc = mul_q16(cy, cp);
        ss = mul_q16(sy, sp);
        sc = mul_q16(sy, cp);
        cs = mul_q16(cy, sp);
        ypr_x = mul_q16(cs, cr) + mul_q16(sc, sr);
        ypr_y = mul_q16(sc, cr) - mul_q16(cs, sr);
        ypr_z = mul_q16(cc, sr) - mul_q16(ss, cr);
        ypr_w = mul_q16(cc, cr) + mul_q16(ss, sr);
    endtask

    function automatic logic [TDATA_W-1:0] pack_point(input longint px, input longint py,
            input longint pz, input longint qx, input longint qy, input longint qz,
            input longint qw);
        return {qw[Q_W-1:0], qz[Q_W-1:0], qy[Q_W-1:0], qx[Q_W-1:0],
                pz[POS_W-1:0], py[POS_W-1:0], px[POS_W-1:0]};
    endfunction

    // Computes the transformed point for one input point under the shadow registers.
    function automatic logic [TDATA_W-1:0] transform_point(input logic [TDATA_W-1:0] d);
        longint p[3];
        longint x, y, z, w, n2;
        longint m[9];
        longint tr[3];
        longint ox, oy, oz, ow;
        for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[i*POS_W +: POS_W]));
        x = longint'($signed(d[3*POS_W +: Q_W]));
        y = longint'($signed(d[3*POS_W + Q_W +: Q_W]));
        z = longint'($signed(d[3*POS_W + 2*Q_W +: Q_W]));
        w = longint'($signed(d[3*POS_W + 3*Q_W +: Q_W]));
        tr = trans;
        if (point_space) begin
            n2 = x*x + y*y + z*z + w*w;
            // A zero quaternion has a zero inverse, so no translation is applied.
            if (n2 == 0) begin
                tr = '{0, 0, 0};
            end else begin
                m[0] = w*w + x*x - y*y - z*z;
                m[1] = 2 * (x*y - w*z);
                m[2] = 2 * (x*z + w*y);
                m[3] = 2 * (x*y + w*z);
                m[4] = w*w - x*x + y*y - z*z;
                m[5] = 2 * (y*z - w*x);
                m[6] = 2 * (x*z - w*y);
                m[7] = 2 * (y*z + w*x);
                m[8] = w*w - x*x - y*y + z*z;
                for (int i = 0; i < 9; i++) m[i] = div_q30(m[i], n2);
                for (int i = 0; i < 3; i++)
                    tr[i] = round_shift(m[3*i] * trans[0] + m[3*i+1] * trans[1]
                                        + m[3*i+2] * trans[2], 30);
            end
        end
        ox = x*ypr_w + ypr_x*w + y*ypr_z - z*ypr_y;
        oy = y*ypr_w + ypr_y*w + z*ypr_x - x*ypr_z;
        oz = z*ypr_w + ypr_z*w + x*ypr_y - y*ypr_x;
        ow = w*ypr_w - (x*ypr_x + y*ypr_y + z*ypr_z);
        return pack_point(clamp(p[0] + tr[0], 32), clamp(p[1] + tr[1], 32),
                          clamp(p[2] + tr[2], 32),
                          clamp(round_shift(ox, 16), 20), clamp(round_shift(oy, 16), 20),
                          clamp(round_shift(oz, 16), 20), clamp(round_shift(ow, 16), 20));
    endfunction

    // Driver: a new point goes out once the previous one has been accepted on the input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (!s_tvalid || in_fire) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_tdata  <= pending_points.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts at input acceptance, checks at output acceptance.
    string field_name[7] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_orient_x",
                             "out_orient_y", "out_orient_z", "out_orient_w"};
    always @(posedge aclk) begin
        logic [TDATA_W-1:0] exp_pt;
        int lsb;
        int wid;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            expected_points = {expected_points, transform_point(s_tdata)};
            if (point_space && s_tdata[TDATA_W-1:3*POS_W] == '0) zero_quat_points++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                $error("output transaction with no point outstanding: %h", m_tdata);
                errors++;
            end else begin
                exp_pt = expected_points.pop_front();
                points_checked++;
                for (int f = 0; f < 7; f++) begin
                    lsb = (f < 3) ? f * POS_W : 3 * POS_W + (f - 3) * Q_W;
                    wid = (f < 3) ? POS_W : Q_W;
                    if (((exp_pt ^ m_tdata) >> lsb) & ((176'd1 << wid) - 1)) begin
                        $error("%s: expected %0h, got %0h", field_name[f],
                               (exp_pt >> lsb) & ((176'd1 << wid) - 1),
                               (m_tdata >> lsb) & ((176'd1 << wid) - 1));
                        errors++;
                    end
                end
            end
        end
    end

    function automatic longint rand_signed(input int w);
        longint v;
        v = {$urandom, $urandom};
        return longint'(v <<< (64 - w)) >>> (64 - w);
    endfunction

    // A random point: quaternion parts mostly within -1 to 1 in Q16.16, sometimes any 20-bit pattern.
    task automatic queue_random_point();
        longint q[4];
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(3) == 0) q[i] = rand_signed(Q_W);
            else q[i] = $signed($urandom_range(131072)) - 65536;
        end
        enqueue_point(pack_point(rand_signed(32), rand_signed(32),
            ($urandom_range(4) == 0) ? rand_signed(32) : rand_signed(24),
            q[0], q[1], q[2], q[3]));
    endtask

    task automatic wait_idle();
        while (pending_points.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        // Let the pipeline drain fully before any register is touched.
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_config(input longint tx, input longint ty, input longint tz,
            input longint yaw, input longint pitch, input longint roll, input longint ps);
        write_reg(REG_TRANS_X, tx);
        write_reg(REG_TRANS_Y, ty);
        write_reg(REG_TRANS_Z, tz);
        write_reg(REG_YAW, yaw);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_ROLL, roll);
        write_reg(REG_POINT_SPACE, ps);
    endtask

    localparam longint T_MAX = 6553600;
    localparam longint A_MAX = 411775;
    // An index past the last register; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    int idle_sets[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{26, 26}};

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_pct  = 0;
        stall_pct = 0;
        errors    = 0;
        points_checked = 0;
        zero_quat_points = 0;
        trans = '{0, 0, 0};
        ang_reg = '{0, 0, 0};
        point_space = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        write_reg(REG_NONE, 0);

        // Directed points: extreme fields, saturation and the zero quaternion.
        set_config(T_MAX, -T_MAX, T_MAX, A_MAX, -A_MAX, A_MAX, 1);
        enqueue_point(pack_point(0, 0, 0, 0, 0, 0, 0));
        enqueue_point(pack_point(32'h7FFFFFFF, 32'h80000000 - 64'sd4294967296,
                                 32'h7FFFFFFF, 0, 0, 0, 0));
        enqueue_point(pack_point(0, 0, 0, 0, 0, 0, 65536));
        enqueue_point(pack_point(0, 0, 0, 524287, 524287, 524287, 524287));
        enqueue_point(pack_point(0, 0, 0, -524288, -524288, -524288, -524288));
        enqueue_point(pack_point(-1, -1, -1, 524287, -524288, 524287, -524288));
        enqueue_point(pack_point(1, 1, 1, 1, 0, 0, 0));
        enqueue_point(pack_point(2147483647, -2147483648, 2147483647,
                                 0, 65536, 0, 0));
        wait_idle();
        set_config(T_MAX, T_MAX, T_MAX, 0, 0, 0, 0);
        enqueue_point(pack_point(2147483647, 2147483647, 2147483647,
                                 524287, 524287, 524287, 524287));
        enqueue_point(pack_point(0, 0, 0, 0, 0, 0, 0));
        enqueue_point(pack_point(-2147483648, -2147483648, -2147483648,
                                 -524288, -524288, -524288, -524288));
        wait_idle();
        set_config(-T_MAX, -T_MAX, -T_MAX, -A_MAX, A_MAX, -A_MAX, 0);
        enqueue_point(pack_point(-2147483648, -2147483648, -2147483648,
                                 0, 0, 0, 65536));
        enqueue_point(pack_point(0, 0, 0, 524287, -524288, 0, 524287));
        enqueue_point(pack_point(5, -5, 5, 0, 0, 65536, 0));
        wait_idle();

        // Random points, with a fresh register setting and idling pattern per phase.
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct  = idle_sets[ph % 4][0];
            stall_pct = idle_sets[ph % 4][1];
            if (ph == 7)
                set_config(-T_MAX, T_MAX, 0, A_MAX, A_MAX, A_MAX, 1);
            else
                set_config(rand_signed(T_W), rand_signed(T_W), $urandom_range(13107200) - T_MAX,
                           rand_signed(ANG_W), $urandom_range(2 * A_MAX) - A_MAX,
                           $urandom_range(2 * A_MAX) - A_MAX, $urandom_range(1));
            for (int n = 0; n < 92; n++) begin
                if (point_space && $urandom_range(30) == 0)
                    enqueue_point(pack_point(rand_signed(32), rand_signed(32),
                                             rand_signed(32), 0, 0, 0, 0));
                else
                    queue_random_point();
            end
            // A stretch with no idling inside each phase.
            if (ph % 4 != 0) begin
                while (pending_points.size() >= 30)
                    @(posedge aclk);
                idle_pct  = 0;
                stall_pct = 0;
            end
            wait_idle();
        end

        $display("Checked %0d transformed points over 11 register settings and 4 idling patterns,",
                 points_checked);
        $display("%0d of them with a zero quaternion in point-space mode.", zero_quat_points);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
